// ===== rtl/utf8d_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 validating decoder.
// No dependencies; imported by every module of the decoder.
package utf8d_pkg;

	localparam int CP_W = 21;
	localparam int HELD_DEPTH = 2;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] MIN_CP2 = 21'h000080;
	localparam logic [CP_W-1:0] MIN_CP3 = 21'h000800;
	localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_CP4 = 21'h010000;
	localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;

	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD_MAX  = 8'hF4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REPLAY
	} state_t;

	// One decoded result.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            rep;
		logic            last;
	} res_t;

	// What the step unit decides for one byte.
	typedef struct packed {
		logic            emit;
		logic            err;
		logic            hold;
		logic [CP_W-1:0] cp;
		logic            rep;
		logic [7:0]      nxt_lead;
		logic [1:0]      nxt_exp;
		logic [CP_W-1:0] nxt_part;
	} step_out_t;

	// A byte seen with no sequence pending gives a result unless it is a lead.
	function automatic logic idle_emits(input logic [7:0] b);
		return !(b >= LEAD2_MIN && b <= LEAD_MAX);
	endfunction

endpackage

// ===== rtl/utf8d_step_unit.sv =====
// Single-byte decode step: classifies a byte against the pending sequence,
// folds continuation bits in and range-checks a finished code point.
// Depends on utf8d_pkg.
module utf8d_step_unit (
	input  logic [7:0]                   in_b,
	input  logic [7:0]                   lead,
	input  logic [1:0]                   exp_cnt,
	input  logic [utf8d_pkg::CP_W-1:0]   part,
	output utf8d_pkg::step_out_t         st
);
	import utf8d_pkg::*;

	logic [CP_W-1:0] acc;
	logic [1:0]      exp_dec;
	logic            val_ok;

	assign acc     = {part[CP_W-7:0], in_b[5:0]};
	assign exp_dec = exp_cnt - 2'd1;

	always_comb begin
		if (lead < LEAD3_MIN) begin
			val_ok = acc >= MIN_CP2;
		end else if (lead < LEAD4_MIN) begin
			val_ok = (acc >= MIN_CP3) && !(acc >= SURR_LO && acc <= SURR_HI);
		end else begin
			val_ok = (acc >= MIN_CP4) && (acc <= MAX_CP);
		end
	end

	always_comb begin
		st          = '0;
		st.nxt_lead = lead;
		st.nxt_exp  = exp_cnt;
		st.nxt_part = part;
		if (exp_cnt == 2'd0) begin
			if (in_b < 8'h80) begin
				st.emit = 1'b1;
				st.cp   = {{(CP_W-8){1'b0}}, in_b};
			end else if (in_b < LEAD2_MIN || in_b > LEAD_MAX) begin
				st.emit = 1'b1;
				st.cp   = REPL_CP;
				st.rep  = 1'b1;
			end else begin
				st.nxt_lead = in_b;
				if (in_b < LEAD3_MIN) begin
					st.nxt_exp  = 2'd1;
					st.nxt_part = {{(CP_W-5){1'b0}}, in_b[4:0]};
				end else if (in_b < LEAD4_MIN) begin
					st.nxt_exp  = 2'd2;
					st.nxt_part = {{(CP_W-4){1'b0}}, in_b[3:0]};
				end else begin
					st.nxt_exp  = 2'd3;
					st.nxt_part = {{(CP_W-3){1'b0}}, in_b[2:0]};
				end
			end
		end else if (in_b[7:6] != 2'b10) begin
			st.emit = 1'b1;
			st.err  = 1'b1;
			st.cp   = REPL_CP;
			st.rep  = 1'b1;
		end else if (exp_dec == 2'd0) begin
			st.emit = 1'b1;
			if (val_ok) begin
				st.cp       = acc;
				st.nxt_lead = '0;
				st.nxt_exp  = '0;
				st.nxt_part = '0;
			end else begin
				st.err = 1'b1;
				st.cp  = REPL_CP;
				st.rep = 1'b1;
			end
		end else begin
			st.hold     = 1'b1;
			st.nxt_exp  = exp_dec;
			st.nxt_part = acc;
		end
	end

endmodule

// ===== rtl/utf8d_out_reg.sv =====
// Output holding register on the result stream.
// Depends on utf8d_pkg.
module utf8d_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  utf8d_pkg::res_t   res,
	output logic              can_load,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [20:0] code_point, [23:21] zero
	output logic              m_tuser,   // [0] replaced
	output logic              m_tlast    // run_end
);
	import utf8d_pkg::*;

	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            rep_q;
	logic            last_q;

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			cp_q   <= res.cp;
			rep_q  <= res.rep;
			last_q <= res.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(24-CP_W){1'b0}}, cp_q};
	assign m_tuser  = rep_q;
	assign m_tlast  = last_q;

endmodule

// ===== rtl/utf8_validating_decoder_core.sv =====
// UTF-8 validating decoder: one byte per request in, Unicode code points out.
// An accepted byte is captured, then makes one pass through the shared decode
// step unit; a broken sequence then replays each held continuation byte and
// the current byte through it, and every result waits for a free output
// register. s_tready is high only while the sequencer is idle. A bad sequence
// gives U+FFFD with m_tuser set, followed by its replayed bytes; m_tlast marks
// the last result caused by an input byte. A sequence still open after the
// byte with s_tlast has been decoded is dropped without output.
// Depends on utf8d_pkg, utf8d_step_unit, utf8d_out_reg.
module utf8_validating_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic        m_tuser,   // [0] replaced
	output logic        m_tlast    // run_end
);
	import utf8d_pkg::*;

	state_t          state_q, state_d;
	logic [7:0]      byte_q;
	logic            last_q;
	logic [7:0]      lead_q;
	logic [1:0]      exp_q;
	logic [CP_W-1:0] part_q;
	logic [1:0]      held_cnt_q;
	logic [1:0]      rep_idx_q;
	logic [7:0]      held_q [HELD_DEPTH];

	logic            accept;
	logic            replay_held;
	logic [7:0]      feed_b;
	logic            emit_req;
	logic            can_load;
	logic            go;
	res_t            res;
	step_out_t       st;

	utf8d_step_unit u_step (
		.in_b    (feed_b),
		.lead    (lead_q),
		.exp_cnt (exp_q),
		.part    (part_q),
		.st      (st)
	);

	utf8d_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit_req),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assign accept = s_tvalid && s_tready;
	assign go     = !emit_req || can_load;

	// outputs of the sequencer
	always_comb begin
		s_tready    = (state_q == S_IDLE);
		replay_held = (state_q == S_REPLAY) && (rep_idx_q < held_cnt_q);
		feed_b      = replay_held ? held_q[rep_idx_q[0]] : byte_q;
		emit_req    = (state_q != S_IDLE) && st.emit;
		res.cp      = st.cp;
		res.rep     = st.rep;
		case (state_q)
			S_EXEC: begin
				res.last = !st.err || (held_cnt_q == 2'd0 && !idle_emits(byte_q));
			end
			S_REPLAY: begin
				res.last = !replay_held ||
					(rep_idx_q == held_cnt_q - 2'd1 && !idle_emits(byte_q));
			end
			default: begin
				res.last = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (go) state_d = st.err ? S_REPLAY : S_IDLE;
			end
			S_REPLAY: begin
				if (go && !replay_held) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lead_q     <= '0;
			exp_q      <= '0;
			part_q     <= '0;
			held_cnt_q <= '0;
			rep_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (go && state_q == S_EXEC && st.err) begin
				lead_q    <= '0;
				exp_q     <= '0;
				part_q    <= '0;
				rep_idx_q <= '0;
			end else if (go && state_q == S_REPLAY && replay_held) begin
				rep_idx_q <= rep_idx_q + 2'd1;
			end else if (go && state_q != S_IDLE) begin
				// end of stream drops an open sequence
				if (last_q && st.nxt_exp != 2'd0) begin
					lead_q <= '0;
					exp_q  <= '0;
					part_q <= '0;
				end else begin
					lead_q <= st.nxt_lead;
					exp_q  <= st.nxt_exp;
					part_q <= st.nxt_part;
				end
				if (st.nxt_exp == 2'd0 || last_q || state_q == S_REPLAY) begin
					held_cnt_q <= '0;
				end else if (st.hold) begin
					held_cnt_q <= held_cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= s_tdata;
			last_q <= s_tlast;
		end
		if (go && state_q == S_EXEC && st.hold) begin
			held_q[held_cnt_q[0]] <= byte_q;
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd3)
		else $error("held byte count out of range");

	a_pending_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && exp_q != 2'd0) |-> (lead_q >= LEAD2_MIN && lead_q <= LEAD_MAX))
		else $error("pending sequence without a valid lead");

	a_replay_repl: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_req && replay_held) |-> (res.rep && res.cp == REPL_CP))
		else $error("replayed continuation byte did not give a replacement");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC && !s_tready))
		else $error("accepted byte not taken to the decode step");

endmodule
